FILE: rtl/lbt_pkg.sv
// lbt_pkg: shared types and constants of the label bounding box table.
// Used by the channel interfaces and the top level.
`default_nettype none

package lbt_pkg;

   localparam int unsigned CMD_W      = 2;
   localparam int unsigned LABEL_W    = 16;
   localparam int unsigned COORD_W    = 12;
   localparam int unsigned FRAME_W    = 16;
   localparam int unsigned EXTENT_W   = 13;
   localparam int unsigned ZOUT_W     = 17;
   localparam int unsigned COUNT_W    = 11;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_FIRST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LAST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_OFFSET     = 3'd4;

   // Stored box of a touched label; starts never exceed the last coordinate.
   typedef struct packed {
      logic                  touched;
      logic [COORD_W-1:0]    xs;
      logic [EXTENT_W-1:0]   xe;
      logic [COORD_W-1:0]    ys;
      logic [EXTENT_W-1:0]   ye;
      logic [FRAME_W-1:0]    zs;
      logic [FRAME_W:0]      ze;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: rtl/lbt_req_if.sv
// lbt_req_if: command channel of the label bounding box table.
// Depends on lbt_pkg for field widths.
`default_nettype none

interface lbt_req_if
   import lbt_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [LABEL_W-1:0]   label_id;
   logic [COORD_W-1:0]   pixel_x;
   logic [COORD_W-1:0]   pixel_y;
   logic [FRAME_W-1:0]   pixel_z;

   modport source (output valid, command, label_id, pixel_x, pixel_y, pixel_z,
                   input ready);
   modport sink   (input valid, command, label_id, pixel_x, pixel_y, pixel_z,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/lbt_rsp_if.sv
// lbt_rsp_if: box result channel of the label bounding box table.
// Depends on lbt_pkg for field widths.
`default_nettype none

interface lbt_rsp_if
   import lbt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [EXTENT_W-1:0]   x_start;
   logic [EXTENT_W-1:0]   x_end;
   logic [EXTENT_W-1:0]   y_start;
   logic [EXTENT_W-1:0]   y_end;
   logic [ZOUT_W-1:0]     z_start;
   logic [ZOUT_W-1:0]     z_end;
   logic [COUNT_W-1:0]    label_count;
   logic                  label_overflow;

   modport source (output valid, x_start, x_end, y_start, y_end, z_start, z_end,
                          label_count, label_overflow,
                   input ready);
   modport sink   (input valid, x_start, x_end, y_start, y_end, z_start, z_end,
                         label_count, label_overflow,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/lbt_ram.sv
// lbt_ram: generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
`default_nettype none

module lbt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/label_bounding_box_table.sv
// label_bounding_box_table: per-label 3D bounding box table over one RAM.
// Depends on lbt_pkg, lbt_req_if, lbt_rsp_if and lbt_ram.
//
//   channel  dir  handshake          carries
//   req_ch   in   valid/ready        command, label_id, pixel_x/y/z
//   rsp_ch   out  valid/ready        box, label_count, label_overflow
//   csr_*    in   csr_we (no wait)   csr_index, csr_wdata
//
// One item per cycle, save in sweeps and read stalls: each item's entry is
// read at acceptance; a pixel item's is modified and written back the next
// cycle, and the last write is forwarded. Reset and every clear item start
// a sweep over all MAX_LABELS entries that marks them untouched and keeps
// req_ch.ready low. A read waits in its stage only while rsp_ch holds an untaken item.
`default_nettype none

module label_bounding_box_table
   import lbt_pkg::*;
#(
   parameter int unsigned MAX_LABELS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lbt_req_if.sink                    req_ch,
   lbt_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
   localparam int unsigned HI_W  = $clog2(MAX_LABELS + 1);
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_LABELS - 1);
   localparam logic [LABEL_W:0]   LABEL_LIM = (LABEL_W + 1)'(MAX_LABELS);

   // configuration
   logic [EXTENT_W-1:0] image_width_ff, image_height_ff;
   logic [FRAME_W-1:0]  frame_first_ff, frame_last_ff, z_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= EXTENT_W'(4096);
         image_height_ff <= EXTENT_W'(4096);
         frame_first_ff  <= '0;
         frame_last_ff   <= '1;
         z_offset_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[EXTENT_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[EXTENT_W-1:0];
            CSR_FRAME_FIRST:  frame_first_ff  <= csr_wdata;
            CSR_FRAME_LAST:   frame_last_ff   <= csr_wdata;
            CSR_Z_OFFSET:     z_offset_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control and stage registers
   logic                 sweep_ff, sweep_in;
   logic [IDX_W-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic [HI_W-1:0]      highest_ff, highest_in;
   logic                 overflow_ff, overflow_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]     s1_cmd_ff;
   logic [LABEL_W-1:0]   s1_label_ff;
   logic [COORD_W-1:0]   s1_x_ff, s1_y_ff;
   logic [FRAME_W-1:0]   s1_z_ff;
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [IDX_W-1:0]     fwd_addr_ff;
   entry_type            fwd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept, accept_clear, s1_is_read, s1_adv, s1_fire;
   logic                 s1_inside, s1_pixel_wr, s1_read_fire;
   logic [IDX_W-1:0]     s1_idx;
   logic [ENTRY_W-1:0]   rd_word;
   entry_type            cur, new_entry;
   logic [LABEL_W:0]     label_ext;
   logic [HI_W-1:0]      label_inc;

   // working box, start values or stored
   logic [EXTENT_W-1:0]  b_xs, b_xe, b_ys, b_ye;
   logic [FRAME_W-1:0]   b_zs;
   logic [FRAME_W:0]     b_ze;
   logic                 use_stored;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;

   assign s1_is_read  = (s1_cmd_ff == CMD_READ);
   assign s1_adv      = !s1_is_read || !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire     = s1_valid_ff && s1_adv;
   assign req_ch.ready = !sweep_ff && (!s1_valid_ff || s1_adv);
   assign accept       = req_ch.valid && req_ch.ready;
   assign accept_clear = accept && (req_ch.command == CMD_CLEAR);

   assign label_ext    = {1'b0, s1_label_ff};
   assign s1_inside    = label_ext < LABEL_LIM;
   assign s1_idx       = s1_label_ff[IDX_W-1:0];
   assign label_inc    = HI_W'(label_ext + (LABEL_W + 1)'(1));
   assign s1_pixel_wr  = s1_fire && (s1_cmd_ff == CMD_PIXEL) && s1_inside;
   assign s1_read_fire = s1_fire && s1_is_read;

   lbt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_LABELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_ch.label_id[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   always_comb begin
      cur = (fwd_valid_ff && fwd_addr_ff == s1_idx) ? fwd_data_ff : entry_type'(rd_word);
      use_stored = cur.touched && s1_inside;
      if (use_stored) begin
         b_xs = {1'b0, cur.xs};
         b_xe = cur.xe;
         b_ys = {1'b0, cur.ys};
         b_ye = cur.ye;
         b_zs = cur.zs;
         b_ze = cur.ze;
      end else begin
         b_xs = image_width_ff;
         b_xe = '0;
         b_ys = image_height_ff;
         b_ye = '0;
         b_zs = frame_last_ff;
         b_ze = {1'b0, frame_first_ff};
      end

      new_entry.touched = 1'b1;
      new_entry.xs = ({1'b0, s1_x_ff} < b_xs) ? s1_x_ff : b_xs[COORD_W-1:0];
      new_entry.xe = ({1'b0, s1_x_ff} >= b_xe) ? EXTENT_W'(s1_x_ff) + EXTENT_W'(1) : b_xe;
      new_entry.ys = ({1'b0, s1_y_ff} < b_ys) ? s1_y_ff : b_ys[COORD_W-1:0];
      new_entry.ye = ({1'b0, s1_y_ff} >= b_ye) ? EXTENT_W'(s1_y_ff) + EXTENT_W'(1) : b_ye;
      new_entry.zs = (s1_z_ff < b_zs) ? s1_z_ff : b_zs;
      new_entry.ze = ({1'b0, s1_z_ff} >= b_ze) ?
                     (FRAME_W + 1)'(s1_z_ff) + (FRAME_W + 1)'(1) : b_ze;

      ram_we    = s1_pixel_wr || sweep_ff;
      ram_waddr = sweep_ff ? sweep_cnt_ff : s1_idx;
      ram_wdata = sweep_ff ? '0 : ENTRY_W'(new_entry);
   end

   always_comb begin
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      highest_in   = highest_ff;
      overflow_in  = overflow_ff;
      fwd_valid_in = fwd_valid_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;

      if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (accept && !accept_clear) begin
         s1_valid_in = 1'b1;
      end

      if (s1_read_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_pixel_wr) begin
         fwd_valid_in = 1'b1;
         if (label_inc > highest_ff) begin
            highest_in = label_inc;
         end
      end
      if (s1_fire && s1_cmd_ff == CMD_PIXEL && !s1_inside) begin
         overflow_in = 1'b1;
      end

      if (sweep_ff) begin
         fwd_valid_in = 1'b0;
         sweep_cnt_in = sweep_cnt_ff + IDX_W'(1);
         if (sweep_cnt_ff == LAST_IDX) begin
            sweep_in = 1'b0;
         end
      end

      // clear is younger than the item in flight and wins
      if (accept_clear) begin
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
         highest_in   = '0;
         overflow_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         highest_ff   <= '0;
         overflow_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_cnt_ff <= sweep_cnt_in;
         highest_ff   <= highest_in;
         overflow_ff  <= overflow_in;
         fwd_valid_ff <= fwd_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= req_ch.command;
         s1_label_ff <= req_ch.label_id;
         s1_x_ff     <= req_ch.pixel_x;
         s1_y_ff     <= req_ch.pixel_y;
         s1_z_ff     <= req_ch.pixel_z;
      end
      if (s1_pixel_wr) begin
         fwd_addr_ff <= s1_idx;
         fwd_data_ff <= new_entry;
      end
      if (s1_read_fire) begin
         rsp_ch.x_start        <= b_xs;
         rsp_ch.x_end          <= b_xe;
         rsp_ch.y_start        <= b_ys;
         rsp_ch.y_end          <= b_ye;
         rsp_ch.z_start        <= ZOUT_W'(b_zs) + ZOUT_W'(z_offset_ff);
         rsp_ch.z_end          <= b_ze + ZOUT_W'(z_offset_ff);
         rsp_ch.label_count    <= COUNT_W'(highest_ff);
         rsp_ch.label_overflow <= overflow_ff;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;

endmodule

`default_nettype wire
